// ----- rtl/xpr_pkg.sv -----
// Shared constants and types for the XOR parity packet recovery block.
`default_nettype none

package xpr_pkg;

    localparam int DEF_GROUP_SIZE    = 3;
    localparam int DEF_TABLE_DEPTH   = 256;
    localparam int DEF_PAYLOAD_WORDS = 20;

    localparam int SEQ_W  = 32;
    localparam int KIND_W = 8;
    localparam int WORD_W = 64;

    localparam logic [KIND_W-1:0] KIND_DATA   = 8'd0;
    localparam logic [KIND_W-1:0] KIND_PARITY = 8'd1;

    typedef struct packed {
        logic store_parity;
        logic forward;
        logic accum;
    } act_t;

endpackage

`default_nettype wire

// ----- rtl/xpr_locate.sv -----
// Pipelined divider that maps a sequence number to its slot and table entry.
`default_nettype none

module xpr_locate
    import xpr_pkg::*;
#(
    parameter int GROUP_SIZE  = DEF_GROUP_SIZE,
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [SEQ_W-1:0]               seq_number,
    output logic                                loc_valid,
    output logic [$clog2(GROUP_SIZE)-1:0]       off,
    output logic [$clog2(TABLE_DEPTH)-1:0]      entry
);

    localparam int OFF_W = $clog2(GROUP_SIZE);
    localparam int EW    = $clog2(TABLE_DEPTH);
    localparam int GSH   = 35;
    localparam logic [63:0] GMUL = (64'd1 << GSH) / GROUP_SIZE;
    localparam int DSH   = 32;
    localparam logic [63:0] DMUL = (64'd1 << DSH) / TABLE_DEPTH;

    logic [3:0]        vld_reg;
    logic [SEQ_W-1:0]  seq1_reg;
    logic [67:0]       prod1_reg;
    logic [31:0]       q_reg;
    logic [OFF_W-1:0]  off2_reg;
    logic [63:0]       prod2_reg;
    logic [31:0]       q3_reg;
    logic [OFF_W-1:0]  off3_reg;
    logic [OFF_W-1:0]  off4_reg;
    logic [EW-1:0]     entry_reg;

    logic [31:0] q1;
    logic [34:0] rem1;
    logic [31:0] q2;
    logic [32:0] rem2;

    always_comb
    begin
        q1   = prod1_reg[66:35];
        rem1 = {3'b000, seq1_reg} - 35'(q1 * 35'(GROUP_SIZE));
        q2   = prod2_reg[63:32];
        rem2 = {1'b0, q3_reg} - 33'(64'(q2) * 64'(TABLE_DEPTH));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        seq1_reg  <= seq_number;
        prod1_reg <= 68'(seq_number) * 68'(GMUL[35:0]);
        if (rem1 >= 35'(GROUP_SIZE))
        begin
            q_reg    <= q1 + 32'd1;
            off2_reg <= OFF_W'(rem1 - 35'(GROUP_SIZE));
        end
        else
        begin
            q_reg    <= q1;
            off2_reg <= OFF_W'(rem1);
        end
        prod2_reg <= 64'(q_reg) * 64'(DMUL[31:0]);
        q3_reg    <= q_reg;
        off3_reg  <= off2_reg;
        off4_reg  <= off3_reg;
        if (rem2 >= 33'(TABLE_DEPTH))
        begin
            entry_reg <= EW'(rem2 - 33'(TABLE_DEPTH));
        end
        else
        begin
            entry_reg <= EW'(rem2);
        end
    end

    assign loc_valid = vld_reg[3];
    assign off       = off4_reg;
    assign entry     = entry_reg;

endmodule

`default_nettype wire

// ----- rtl/xor_parity_packet_recovery.sv -----
// Top level of the XOR parity packet recovery block.
// Each payload word request passes through the pipelined sequence-to-entry division and then the
// read, modify and write of the entry and data memories, with busy high; a new request is taken
// only while idle. The final word of a packet that completes a group with parity then rebuilds
// the missing packet, one memory read and one output per rebuilt word, during which
// busy stays high. Results appear as single-cycle out_valid strobes and cannot be stalled.
// After reset the block clears its memories with busy high.
`default_nettype none

module xor_parity_packet_recovery
    import xpr_pkg::*;
#(
    parameter int GROUP_SIZE    = DEF_GROUP_SIZE,
    parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
    parameter int PAYLOAD_WORDS = DEF_PAYLOAD_WORDS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [SEQ_W-1:0]   seq_number,
    input  wire logic [KIND_W-1:0]  packet_kind,
    input  wire logic [WORD_W-1:0]  payload_word,
    input  wire logic               end_of_packet,
    output logic                    out_valid,
    output logic [SEQ_W-1:0]        out_seq,
    output logic [WORD_W-1:0]       out_word,
    output logic                    out_last,
    output logic                    recovered
);

    localparam int OFF_W  = $clog2(GROUP_SIZE);
    localparam int EW     = $clog2(TABLE_DEPTH);
    localparam int PW_W   = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;
    localparam int DDEPTH = TABLE_DEPTH * PAYLOAD_WORDS;
    localparam int AW     = $clog2(DDEPTH);
    localparam int MW     = 2 * GROUP_SIZE + 1;

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_LOC, S_RD, S_UPD, S_RBRD, S_RBOUT
    } state_t;

    state_t              state_reg;
    logic [AW-1:0]       clr_reg;
    logic [SEQ_W-1:0]    seq_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [WORD_W-1:0]   word_reg;
    logic                eop_reg;
    logic [EW-1:0]       entry_reg;
    logic [OFF_W-1:0]    off_reg;
    logic [PW_W-1:0]     pos_reg;
    act_t                act_reg;
    logic [PW_W-1:0]     rb_k_reg;
    logic [SEQ_W-1:0]    rb_seq_reg;

    logic [MW-1:0]       meta_mem [TABLE_DEPTH];
    logic [2*WORD_W-1:0] data_mem [DDEPTH];
    logic [MW-1:0]       meta_q;
    logic [2*WORD_W-1:0] data_q;

    logic                loc_valid;
    logic [OFF_W-1:0]    loc_off;
    logic [EW-1:0]       loc_entry;

    logic                accept;
    logic [AW-1:0]       base_addr;
    logic [AW-1:0]       cell_addr;
    logic [AW-1:0]       d_raddr;
    logic                d_we;
    logic [AW-1:0]       d_waddr;
    logic [2*WORD_W-1:0] d_wdata;
    logic                m_we;
    logic [EW-1:0]       m_waddr;
    logic [MW-1:0]       m_wdata;

    logic [GROUP_SIZE-1:0] arr;
    logic [GROUP_SIZE-1:0] snt;
    logic                  held;
    logic [GROUP_SIZE-1:0] bit_mask;
    act_t                  new_act;
    act_t                  act_cur;
    logic                  last;
    logic [GROUP_SIZE-1:0] arr_n;
    logic [GROUP_SIZE-1:0] snt_n;
    logic [GROUP_SIZE-1:0] snt_f;
    logic                  held_n;
    logic [OFF_W-1:0]      slot;
    logic                  rb_go;
    logic [SEQ_W-1:0]      grp_start;
    logic [WORD_W-1:0]     xor_new;
    logic [WORD_W-1:0]     par_new;
    logic                  clr_meta;

    xpr_locate #(
        .GROUP_SIZE  (GROUP_SIZE),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_locate (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept),
        .seq_number (seq_number),
        .loc_valid  (loc_valid),
        .off        (loc_off),
        .entry      (loc_entry)
    );

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && (state_reg == S_IDLE);
    assign base_addr = AW'(AW'(entry_reg) * AW'(PAYLOAD_WORDS));
    assign cell_addr = base_addr + AW'(pos_reg);
    assign d_raddr   = (state_reg == S_RBRD) ? (base_addr + AW'(rb_k_reg)) : cell_addr;
    assign clr_meta  = (64'(clr_reg) < 64'(TABLE_DEPTH));

    always_comb
    begin
        arr      = meta_q[GROUP_SIZE-1:0];
        snt      = meta_q[2*GROUP_SIZE-1:GROUP_SIZE];
        held     = meta_q[2*GROUP_SIZE];
        bit_mask = GROUP_SIZE'(1) << off_reg;
        new_act  = '0;
        if (kind_reg == KIND_DATA)
        begin
            new_act.accum   = !(|(arr & bit_mask));
            new_act.forward = !(|(snt & bit_mask));
        end
        else if (kind_reg == KIND_PARITY)
        begin
            new_act.store_parity = !held;
        end
        act_cur = (pos_reg == '0) ? new_act : act_reg;
        last    = eop_reg || (pos_reg == PW_W'(PAYLOAD_WORDS - 1));
        arr_n   = arr | (act_cur.accum ? bit_mask : '0);
        snt_n   = snt | (act_cur.forward ? bit_mask : '0);
        held_n  = held | act_cur.store_parity;
        slot    = '0;
        for (int i = GROUP_SIZE - 1; i >= 0; i--)
        begin
            if (!arr_n[i])
            begin
                slot = OFF_W'(i);
            end
        end
        rb_go = last && ((kind_reg == KIND_DATA) || (kind_reg == KIND_PARITY)) && held_n
                && ($countones(arr_n) == GROUP_SIZE - 1) && !snt_n[slot];
        snt_f = snt_n | (rb_go ? (GROUP_SIZE'(1) << slot) : '0);
        grp_start = (kind_reg == KIND_DATA) ? (seq_reg - SEQ_W'(off_reg)) : seq_reg;
        xor_new = act_cur.accum ? (data_q[WORD_W-1:0] ^ word_reg) : data_q[WORD_W-1:0];
        par_new = act_cur.store_parity ? word_reg : data_q[2*WORD_W-1:WORD_W];

        d_we    = 1'b0;
        d_waddr = cell_addr;
        d_wdata = {par_new, xor_new};
        m_we    = 1'b0;
        m_waddr = entry_reg;
        m_wdata = {held_n, snt_f, arr_n};
        if (state_reg == S_CLR)
        begin
            d_we    = 1'b1;
            d_waddr = clr_reg;
            d_wdata = '0;
            m_we    = clr_meta;
            m_waddr = EW'(clr_reg);
            m_wdata = '0;
        end
        else if (state_reg == S_UPD)
        begin
            d_we = act_cur.accum || act_cur.store_parity;
            m_we = last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_we)
        begin
            data_mem[d_waddr] <= d_wdata;
        end
        data_q <= data_mem[d_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (m_we)
        begin
            meta_mem[m_waddr] <= m_wdata;
        end
        meta_q <= meta_mem[entry_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            pos_reg   <= '0;
            act_reg   <= '0;
            rb_k_reg  <= '0;
            out_valid <= 1'b0;
            out_last  <= 1'b0;
            recovered <= 1'b0;
        end
        else
        begin
            out_valid <= ((state_reg == S_UPD) && act_cur.forward) || (state_reg == S_RBOUT);
            unique case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(DDEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        seq_reg   <= seq_number;
                        kind_reg  <= packet_kind;
                        word_reg  <= payload_word;
                        eop_reg   <= end_of_packet;
                        state_reg <= S_LOC;
                    end
                end
                S_LOC:
                begin
                    if (loc_valid)
                    begin
                        entry_reg <= loc_entry;
                        off_reg   <= loc_off;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    if (act_cur.forward)
                    begin
                        out_seq   <= seq_reg;
                        out_word  <= word_reg;
                        out_last  <= last;
                        recovered <= 1'b0;
                    end
                    if (last)
                    begin
                        pos_reg <= '0;
                        act_reg <= '0;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + PW_W'(1);
                        act_reg <= act_cur;
                    end
                    rb_k_reg   <= '0;
                    rb_seq_reg <= grp_start + SEQ_W'(slot);
                    state_reg  <= rb_go ? S_RBRD : S_IDLE;
                end
                S_RBRD:
                begin
                    state_reg <= S_RBOUT;
                end
                S_RBOUT:
                begin
                    out_seq   <= rb_seq_reg;
                    out_word  <= data_q[2*WORD_W-1:WORD_W] ^ data_q[WORD_W-1:0];
                    out_last  <= (rb_k_reg == PW_W'(PAYLOAD_WORDS - 1));
                    recovered <= 1'b1;
                    rb_k_reg  <= rb_k_reg + PW_W'(1);
                    if (rb_k_reg == PW_W'(PAYLOAD_WORDS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_RBRD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- test/tb_xor_parity_packet_recovery.sv -----
// Testbench for the XOR parity packet recovery block: directed table, random groups and noise, self-check.
`default_nettype none

module tb_xor_parity_packet_recovery;
    import xpr_pkg::*;

    localparam int GS = DEF_GROUP_SIZE;
    localparam int TD = DEF_TABLE_DEPTH;
    localparam int PW = DEF_PAYLOAD_WORDS;
    localparam int ITEM_TARGET = 180;
    localparam int DRAIN_CYCLES = 64;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [WORD_W-1:0] word;
        logic              last;
        logic              rec;
    } emitted_t;

    typedef struct {
        logic [SEQ_W-1:0]  seq;
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] word;
        int                nwords;
        logic              eop;
        bit                typed;
        logic [SEQ_W-1:0]  xseq;
        logic [WORD_W-1:0] xword;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [SEQ_W-1:0]   seq_number = '0;
    logic [KIND_W-1:0]  packet_kind = '0;
    logic [WORD_W-1:0]  payload_word = '0;
    logic               end_of_packet = 1'b0;
    logic               busy;
    logic               out_valid;
    logic [SEQ_W-1:0]   out_seq;
    logic [WORD_W-1:0]  out_word;
    logic               out_last;
    logic               recovered;

    // Predictor state for the group table.
    logic [GS-1:0]     arrived_mask [TD];
    logic [GS-1:0]     sent_mask [TD];
    bit                parity_ok [TD];
    int                arrived_cnt [TD];
    logic [WORD_W-1:0] data_xor [TD*PW];
    logic [WORD_W-1:0] parity_mem [TD*PW];
    bit                parity_written [TD*PW];
    int                word_idx;
    act_t              pkt_act;

    emitted_t expected_words [$];
    int errors = 0;
    int words_sent = 0;
    int packets_sent = 0;
    int rebuilt_seen = 0;
    int forwarded_seen = 0;
    int burst_left = 0;
    bit paused = 1'b0;

    xor_parity_packet_recovery dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .seq_number(seq_number),
        .packet_kind(packet_kind),
        .payload_word(payload_word),
        .end_of_packet(end_of_packet),
        .out_valid(out_valid),
        .out_seq(out_seq),
        .out_word(out_word),
        .out_last(out_last),
        .recovered(recovered)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(8 * 400000);
        $display("FAILURE");
        $finish;
    end

    function automatic void rebuild_missing(int ent, logic [SEQ_W-1:0] first_seq);
        int base;
        if (!parity_ok[ent] || arrived_cnt[ent] != GS - 1)
            return;
        base = ent * PW;
        for (int sl = 0; sl < GS; sl++)
        begin
            if (!arrived_mask[ent][sl])
            begin
                if (!sent_mask[ent][sl])
                begin
                    for (int k = 0; k < PW; k++)
                        expected_words.push_back('{first_seq + sl,
                            parity_mem[base+k] ^ data_xor[base+k], k == PW - 1, 1'b1});
                    sent_mask[ent][sl] = 1'b1;
                end
                break;
            end
        end
    endfunction

    function automatic void predict_word(logic [SEQ_W-1:0] s, logic [KIND_W-1:0] kd,
                                         logic [WORD_W-1:0] w, logic eop);
        int unsigned slot;
        int ent;
        int idx;
        logic last;
        slot = s % GS;
        ent = (s / GS) % TD;
        if (word_idx >= PW)
            word_idx = 0;
        if (word_idx == 0)
        begin
            pkt_act = '0;
            if (kd == KIND_DATA)
            begin
                pkt_act.accum = !arrived_mask[ent][slot];
                pkt_act.forward = !sent_mask[ent][slot];
            end
            else if (kd == KIND_PARITY)
                pkt_act.store_parity = !parity_ok[ent];
        end
        last = eop || word_idx >= PW - 1;
        idx = ent * PW + word_idx;
        if (pkt_act.accum)
            data_xor[idx] ^= w;
        if (pkt_act.store_parity)
        begin
            parity_mem[idx] = w;
            parity_written[idx] = 1'b1;
        end
        if (pkt_act.forward)
            expected_words.push_back('{s, w, last, 1'b0});
        if (last)
        begin
            if (pkt_act.accum && !arrived_mask[ent][slot])
            begin
                arrived_mask[ent][slot] = 1'b1;
                arrived_cnt[ent]++;
            end
            if (pkt_act.forward)
                sent_mask[ent][slot] = 1'b1;
            if (pkt_act.store_parity)
                parity_ok[ent] = 1'b1;
            if (kd == KIND_DATA)
                rebuild_missing(ent, s - slot);
            else if (kd == KIND_PARITY)
                rebuild_missing(ent, s);
            word_idx = 0;
            pkt_act = '0;
        end
        else
            word_idx++;
    endfunction

    task automatic send_word(logic [SEQ_W-1:0] s, logic [KIND_W-1:0] kd,
                             logic [WORD_W-1:0] w, logic eop);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 30);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        start <= 1'b1;
        seq_number <= s;
        packet_kind <= kd;
        payload_word <= w;
        end_of_packet <= eop;
        do
            @(posedge clk);
        while (busy);
        predict_word(s, kd, w, eop);
        words_sent++;
    endtask

    task automatic send_packet(logic [SEQ_W-1:0] s, logic [KIND_W-1:0] kd, int len,
                               logic eop_at_end);
        for (int k = 0; k < len; k++)
            send_word(s, kd, {$urandom, $urandom}, (k == len - 1) ? eop_at_end : 1'b0);
        packets_sent++;
    endtask

    function automatic int pick_len();
        return ($urandom_range(0, 5) == 0) ? PW : $urandom_range(1, 4);
    endfunction

    // A short parity packet that would be stored must not leave unwritten words behind.
    function automatic int parity_len(logic [SEQ_W-1:0] s, int len);
        int ent;
        ent = (s / GS) % TD;
        if (parity_ok[ent])
            return len;
        for (int k = len; k < PW; k++)
            if (!parity_written[ent*PW+k])
                return PW;
        return len;
    endfunction

    task automatic send_group();
        int unsigned g;
        int order [GS+1];
        int n;
        int missing;
        int len;
        int j;
        int t;
        if ($urandom_range(0, 9) == 0)
            g = $urandom_range(0, 32'h5555_5554);
        else
            g = $urandom_range(0, 3) * TD + $urandom_range(0, 11);
        missing = $urandom_range(0, GS - 1);
        n = 0;
        for (int sl = 0; sl < GS; sl++)
            if (sl != missing || $urandom_range(0, 4) == 0)
            begin
                order[n] = sl;
                n++;
            end
        order[n] = GS;
        n++;
        for (int i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < n; i++)
        begin
            len = pick_len();
            if (order[i] == GS)
            begin
                len = parity_len(g * GS, len);
                send_packet(g * GS, KIND_PARITY, len, len < PW ? 1'b1 : 1'($urandom));
            end
            else
                send_packet(g * GS + order[i], KIND_DATA, len,
                            len < PW ? 1'b1 : 1'($urandom));
        end
    endtask

    task automatic send_noise();
        logic [SEQ_W-1:0] s;
        logic [KIND_W-1:0] kd;
        int len;
        s = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 3 * 4 * TD);
        len = pick_len();
        case ($urandom_range(0, 2))
            0: kd = KIND_DATA;
            1:
            begin
                kd = KIND_PARITY;
                len = parity_len(s, len);
            end
            default: kd = KIND_W'($urandom_range(2, 255));
        endcase
        send_packet(s, kd, len, len < PW ? 1'b1 : 1'($urandom));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        emitted_t want;
        if (rst_n && out_valid)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word seq %h word %h", $time, out_seq, out_word);
                errors++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (out_seq !== want.seq || out_word !== want.word
                    || out_last !== want.last || recovered !== want.rec)
                begin
                    $display("%0t: mismatch expected seq %h word %h last %b rec %b", $time,
                             want.seq, want.word, want.last, want.rec);
                    $display("%0t:          actual   seq %h word %h last %b rec %b", $time,
                             out_seq, out_word, out_last, recovered);
                    errors++;
                end
                if (want.rec)
                    rebuilt_seen++;
                else
                    forwarded_seen++;
            end
        end
    end

    initial
    begin
        stim_row_t rows [$];
        int qbase;
        for (int e = 0; e < TD; e++)
        begin
            arrived_mask[e] = '0;
            sent_mask[e] = '0;
            parity_ok[e] = 1'b0;
            arrived_cnt[e] = 0;
        end
        for (int c = 0; c < TD * PW; c++)
        begin
            data_xor[c] = '0;
            parity_mem[c] = '0;
            parity_written[c] = 1'b0;
        end
        word_idx = 0;
        pkt_act = '0;

        rows = '{
            '{32'd0, KIND_DATA, '1, 1, 1'b1, 1, 32'd0, '1},
            '{32'd1, KIND_DATA, '0, 1, 1'b1, 1, 32'd1, '0},
            '{32'd0, KIND_PARITY, 64'h0123_4567_89AB_CDEF, PW, 1'b1, 0, '0, '0},
            '{32'd0, KIND_DATA, 64'h1, 1, 1'b1, 0, '0, '0},
            '{32'd2, KIND_DATA, 64'h2, 2, 1'b1, 0, '0, '0},
            '{32'd5, 8'hFF, 64'h3, 3, 1'b1, 0, '0, '0},
            '{32'd5, 8'h80, 64'h4, 1, 1'b1, 0, '0, '0},
            '{32'd3, KIND_DATA, 64'h5555_5555_5555_5555, PW, 1'b0, 0, '0, '0},
            '{32'hFFFF_FFFF, KIND_DATA, 64'hAAAA_AAAA_AAAA_AAAA, 1, 1'b1, 1,
              32'hFFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA},
            '{32'd252, KIND_DATA, 64'hFEDC_BA98_7654_3210, 3, 1'b1, 0, '0, '0},
            '{32'd253, KIND_DATA, 64'h8000_0000_0000_0001, 1, 1'b1, 0, '0, '0},
            '{32'hFFFF_FFFE, KIND_PARITY, 64'h7FFF_FFFF_FFFF_FFFE, PW, 1'b1, 0, '0, '0},
            '{32'd0, KIND_PARITY, 64'h6, 2, 1'b1, 0, '0, '0},
            '{32'd6, KIND_DATA, 64'h7, 1, 1'b0, 0, '0, '0},
            '{32'd7, KIND_DATA, 64'h8, 1, 1'b1, 0, '0, '0},
            '{32'd768, KIND_DATA, 64'h9, 1, 1'b1, 0, '0, '0}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[r])
        begin
            for (int k = 0; k < rows[r].nwords; k++)
            begin
                qbase = expected_words.size();
                send_word(rows[r].seq, rows[r].kind, rows[r].word,
                          (k == rows[r].nwords - 1) ? rows[r].eop : 1'b0);
                if (rows[r].typed && expected_words.size() > qbase)
                    expected_words[qbase] = '{rows[r].xseq, rows[r].xword, 1'b1, 1'b0};
            end
            packets_sent++;
        end

        qbase = words_sent;
        while (words_sent < qbase + ITEM_TARGET)
        begin
            if ($urandom_range(0, 9) < 7)
                send_group();
            else
                send_noise();
            if (!paused && words_sent >= qbase + ITEM_TARGET / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
        end
        wait_drained();

        $display("Sent %0d payload words in %0d packets.", words_sent, packets_sent);
        $display("Checked %0d forwarded and %0d rebuilt words.", forwarded_seen, rebuilt_seen);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
